>>> design/ibus_frame_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// ibus_frame_decoder_unit_assert.svh
// Assertion macros for the frame decoder; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef IBUS_FRAME_DECODER_UNIT_ASSERT_SVH
`define IBUS_FRAME_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Condition checked at every clock edge outside reset.
`define IBFD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Trigger implies condition on the following edge.
`define IBFD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);
`else
`define IBFD_ASSERT(lbl, cond, msg)
`define IBFD_ASSERT_NEXT(lbl, trig, cond, msg)
`endif

`endif

>>> design/ibfd_pkg.sv
// ----------------------------------------------------------------------------
// ibfd_pkg
// Widths, frame layout positions and reset constants of the frame decoder.
// ----------------------------------------------------------------------------
package ibfd_pkg;

  localparam int BYTE_W    = 8;
  localparam int CHAN_W    = 16;
  localparam int POS_W     = 5;
  localparam int NUM_CHANS = 10;
  localparam int CH_IDX_W  = 4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CHAN_W-1:0] chan_word_t;
  typedef logic [POS_W-1:0]  pos_t;

  // frame layout
  localparam pos_t POS_LEN       = 5'd0;
  localparam pos_t POS_CMD       = 5'd1;
  localparam pos_t POS_CHAN_LO   = 5'd2;
  localparam pos_t POS_CHAN_HI   = 5'd3;
  localparam pos_t POS_CHAN_LAST = 5'd21;
  localparam pos_t POS_CHECK_LO  = 5'd30;
  localparam pos_t POS_CHECK_HI  = 5'd31;

  localparam byte_t      FRAME_LEN_BYTE = 8'd32;
  localparam byte_t      CMD_RESET      = 8'd64;
  localparam chan_word_t SUM_START      = 16'hFFFF;
  localparam chan_word_t CHAN_RESET     = 16'd1000;

endpackage

>>> design/ibus_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// ibus_frame_decoder_unit: 32-byte servo frame decoder, one byte per cycle
// unless stalled at a frame's last byte; a byte is registered, then decoded.
// Result beat is registered when the frame's last byte leaves the input
// register; that byte waits there while the previous result is not taken.
// Sync reset: position 0, channels 1000 each, command byte 64, no result.
// ----------------------------------------------------------------------------
`include "ibus_frame_decoder_unit_assert.svh"

module ibus_frame_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  ibfd_pkg::byte_t     cfg_write_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  ibfd_pkg::byte_t     rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output ibfd_pkg::chan_word_t chan_0,
  output ibfd_pkg::chan_word_t chan_1,
  output ibfd_pkg::chan_word_t chan_2,
  output ibfd_pkg::chan_word_t chan_3,
  output ibfd_pkg::chan_word_t chan_4,
  output ibfd_pkg::chan_word_t chan_5,
  output ibfd_pkg::chan_word_t chan_6,
  output ibfd_pkg::chan_word_t chan_7,
  output ibfd_pkg::chan_word_t chan_8,
  output ibfd_pkg::chan_word_t chan_9,
  output logic                frame_good
);
  import ibfd_pkg::*;

  byte_t                     command_byte;
  logic                      s1_valid;
  byte_t                     s1_byte;
  pos_t                      pos;
  chan_word_t                running_sum;
  logic                      header_good;
  byte_t                     low_byte_hold;
  byte_t                     check_lo;
  logic [NUM_CHANS-1:0][CHAN_W-1:0] pending;
  logic [NUM_CHANS-1:0][CHAN_W-1:0] held;

  logic                      out_free;
  logic                      s1_fire;
  logic                      is_last;
  logic                      is_low_byte;
  logic                      is_high_byte;
  pos_t                      pos_m3;
  logic [CH_IDX_W-1:0]       ch_idx;
  logic                      ok_next;
  chan_word_t                byte_ext;

  assign out_free     = !out_valid || out_ready;
  assign is_last      = (pos == POS_CHECK_HI);
  // final byte of a frame needs the result register free
  assign s1_fire      = s1_valid && (!is_last || out_free);
  assign in_ready     = !s1_valid || s1_fire;

  assign is_low_byte  = (pos >= POS_CHAN_LO) && (pos <= POS_CHAN_LAST) && !pos[0];
  assign is_high_byte = (pos >= POS_CHAN_HI) && (pos <= POS_CHAN_LAST) && pos[0];
  assign pos_m3       = pos - POS_CHAN_HI;
  assign ch_idx       = pos_m3[CH_IDX_W:1];
  assign byte_ext     = {{(CHAN_W-BYTE_W){1'b0}}, s1_byte};
  assign ok_next      = header_good && ({s1_byte, check_lo} == running_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      command_byte <= CMD_RESET;
    end else if (cfg_write_en) begin
      command_byte <= cfg_write_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      running_sum   <= SUM_START;
      header_good   <= 1'b0;
      low_byte_hold <= '0;
      check_lo      <= '0;
    end else if (s1_fire) begin
      pos <= pos + 5'd1;
      if (pos == POS_LEN) begin
        running_sum <= SUM_START - byte_ext;
        header_good <= (s1_byte == FRAME_LEN_BYTE);
      end else if (pos < POS_CHECK_LO) begin
        running_sum <= running_sum - byte_ext;
        if (pos == POS_CMD) begin
          header_good <= header_good && (s1_byte == command_byte);
        end
      end
      if (is_low_byte) begin
        low_byte_hold <= s1_byte;
      end
      if (pos == POS_CHECK_LO) begin
        check_lo <= s1_byte;
      end
    end
  end

  // pending channel words, no reset: every entry is rewritten before use
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHANS; i++) begin
      if (s1_fire && is_high_byte && (ch_idx == CH_IDX_W'(i))) begin
        pending[i] <= {s1_byte, low_byte_hold};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANS; i++) begin
        held[i] <= CHAN_RESET;
      end
    end else if (s1_fire && is_last && ok_next) begin
      held <= pending;
    end
  end

  // result register; channel values are the held registers themselves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && is_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && is_last) begin
      frame_good <= ok_next;
    end
  end

  assign chan_0 = held[0];
  assign chan_1 = held[1];
  assign chan_2 = held[2];
  assign chan_3 = held[3];
  assign chan_4 = held[4];
  assign chan_5 = held[5];
  assign chan_6 = held[6];
  assign chan_7 = held[7];
  assign chan_8 = held[8];
  assign chan_9 = held[9];

  `IBFD_ASSERT(a_no_overrun, !(s1_fire && is_last && out_valid && !out_ready), "result overrun")
  `IBFD_ASSERT_NEXT(a_held_only_ok, !(s1_fire && is_last && ok_next), $stable(held), "held changed on bad frame")
  `IBFD_ASSERT(a_result_at_wrap, !$rose(out_valid) || (pos == POS_LEN), "result not at frame end")

endmodule
